FILE: rtl/rapd_pkg.sv
package rapd_pkg;

   // Sizing
   localparam int MAX_WINDOW = 16;
   localparam int SIG_BITS   = 32;
   localparam int IDX_W      = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

   // Field and register widths
   localparam int WIN_W      = 5;
   localparam int RLVL_W     = 5;
   localparam int PLVL_W     = 4;
   localparam int RUN_W      = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_WARN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_CRIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PINGPONG_WARN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PINGPONG_CRIT  = 3'd4;

   // Register reset values
   localparam logic [WIN_W-1:0]  WINDOW_RST  = 5'd16;
   localparam logic [RLVL_W-1:0] RWARN_RST   = 5'd3;
   localparam logic [RLVL_W-1:0] RCRIT_RST   = 5'd5;
   localparam logic [PLVL_W-1:0] PWARN_RST   = 4'd2;
   localparam logic [PLVL_W-1:0] PCRIT_RST   = 4'd4;

   // Command codes
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Result codes
   localparam logic [1:0] SEV_NONE      = 2'd0;
   localparam logic [1:0] SEV_WARN      = 2'd1;
   localparam logic [1:0] SEV_CRIT      = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_REPEAT   = 2'd1;
   localparam logic [1:0] KIND_PINGPONG = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // input transaction taken this cycle
      logic issue;    // read next history entry
      logic finish;   // load result register
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_read;  // current read is the oldest valid entry
      logic no_reads;   // fewer than two entries, nothing to walk
      logic out_free;   // result register can take a new result
   } dp_sts_type;

   // Saturate a count to the result field
   function automatic logic [RUN_W-1:0] sat_run(input logic [CNT_W-1:0] cnt);
      if (32'(cnt) > 32'((1 << RUN_W) - 1)) begin
         sat_run = {RUN_W{1'b1}};
      end else begin
         sat_run = RUN_W'(cnt);
      end
   endfunction

endpackage

FILE: rtl/rapd_req_if.sv
interface rapd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [rapd_pkg::SIG_BITS-1:0] signature;

   modport source (output valid, command, signature, input ready);
   modport sink   (input valid, command, signature, output ready);
endinterface

FILE: rtl/rapd_rsp_if.sv
interface rapd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 severity;
   logic [1:0]                 loop_kind;
   logic [rapd_pkg::RUN_W-1:0] run_count;

   modport source (output valid, severity, loop_kind, run_count, input ready);
   modport sink   (input valid, severity, loop_kind, run_count, output ready);
endinterface

FILE: rtl/rapd_ram.sv
module rapd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rapd_ctrl.sv
module rapd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rapd_pkg::dp_sts_type sts,
   output rapd_pkg::dp_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.no_reads) begin
               state_in = ST_FINISH;
            end else begin
               cmd.issue = 1'b1;
               if (sts.last_read) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // last read data lands this cycle
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/rapd_dp.sv
module rapd_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_command,
   input  logic [rapd_pkg::SIG_BITS-1:0]         req_signature,
   input  logic                                  csr_wr_en,
   input  logic [rapd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rapd_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  rapd_pkg::dp_cmd_type                  cmd,
   output rapd_pkg::dp_sts_type                  sts,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_severity,
   output logic [1:0]                            rsp_loop_kind,
   output logic [rapd_pkg::RUN_W-1:0]            rsp_run_count
);

   localparam int IDX_W = rapd_pkg::IDX_W;
   localparam int CNT_W = rapd_pkg::CNT_W;
   localparam int SIG_W = rapd_pkg::SIG_BITS;

   // Configuration registers
   logic [rapd_pkg::WIN_W-1:0]  win_size_ff;
   logic [rapd_pkg::RLVL_W-1:0] rwarn_ff, rcrit_ff;
   logic [rapd_pkg::PLVL_W-1:0] pwarn_ff, pcrit_ff;

   // History bookkeeping
   logic [IDX_W-1:0] hp_ff, hp_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             clear_ff, clear_in;

   // Walk state
   logic [SIG_W-1:0] sig_a_ff, sig_a_in;
   logic [SIG_W-1:0] sig_b_ff, sig_b_in;
   logic [SIG_W-1:0] sig_x_ff, sig_x_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0] rd_k_ff, rd_k_in;
   logic             rep_run_ff, rep_run_in;
   logic [CNT_W-1:0] reps_ff, reps_in;
   logic             pp_run_ff, pp_run_in;
   logic [CNT_W-1:0] cyc_ff, cyc_in;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   sev_ff, sev_in;
   logic [1:0]                   kind_ff, kind_in;
   logic [rapd_pkg::RUN_W-1:0]   run_ff, run_in;

   logic [CNT_W-1:0] win_eff;
   logic [CNT_W:0]   fill_sum;
   logic [IDX_W:0]   rd_sum;
   logic [IDX_W-1:0] rd_addr;
   logic             ram_we;
   logic [SIG_W-1:0] rd_data;
   logic [CNT_W-1:0] cyc_eff;
   logic             pair_ok;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= rapd_pkg::WINDOW_RST;
         rwarn_ff    <= rapd_pkg::RWARN_RST;
         rcrit_ff    <= rapd_pkg::RCRIT_RST;
         pwarn_ff    <= rapd_pkg::PWARN_RST;
         pcrit_ff    <= rapd_pkg::PCRIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            rapd_pkg::CSR_WINDOW_SIZE:   win_size_ff <= csr_wr_data[rapd_pkg::WIN_W-1:0];
            rapd_pkg::CSR_REPEAT_WARN:   rwarn_ff    <= csr_wr_data[rapd_pkg::RLVL_W-1:0];
            rapd_pkg::CSR_REPEAT_CRIT:   rcrit_ff    <= csr_wr_data[rapd_pkg::RLVL_W-1:0];
            rapd_pkg::CSR_PINGPONG_WARN: pwarn_ff    <= csr_wr_data[rapd_pkg::PLVL_W-1:0];
            rapd_pkg::CSR_PINGPONG_CRIT: pcrit_ff    <= csr_wr_data[rapd_pkg::PLVL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective window: zero acts as one, clamp at the store depth
   always_comb begin
      if (win_size_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (32'(win_size_ff) > 32'(rapd_pkg::MAX_WINDOW)) begin
         win_eff = CNT_W'(rapd_pkg::MAX_WINDOW);
      end else begin
         win_eff = CNT_W'(win_size_ff);
      end
   end

   // Circular history: newest entry at hp, entry k at hp - k
   assign fill_sum = {1'b0, fill_ff} + (CNT_W+1)'(1);
   assign rd_sum   = {1'b0, hp_ff} + (IDX_W+1)'(rapd_pkg::MAX_WINDOW) - {1'b0, k_ff};
   assign rd_addr  = (rd_sum >= (IDX_W+1)'(rapd_pkg::MAX_WINDOW)) ?
                     IDX_W'(rd_sum - (IDX_W+1)'(rapd_pkg::MAX_WINDOW)) : rd_sum[IDX_W-1:0];
   assign ram_we   = cmd.accept && (req_command == rapd_pkg::CMD_RECORD);

   always_comb begin
      if (hp_ff == IDX_W'(rapd_pkg::MAX_WINDOW - 1)) begin
         hp_in = '0;
      end else begin
         hp_in = hp_ff + IDX_W'(1);
      end
   end

   rapd_ram #(
      .WIDTH (SIG_W),
      .DEPTH (rapd_pkg::MAX_WINDOW)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hp_in),
      .wr_data (req_signature),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Pair check against the newest two values, either order
   assign pair_ok = ((sig_x_ff == sig_a_ff) && (rd_data == sig_b_ff)) ||
                    ((sig_x_ff == sig_b_ff) && (rd_data == sig_a_ff));

   // Accept, read issue and walk over returned entries
   always_comb begin
      clear_in    = clear_ff;
      fill_in     = fill_ff;
      sig_a_in    = sig_a_ff;
      sig_b_in    = sig_b_ff;
      sig_x_in    = sig_x_ff;
      k_in        = k_ff;
      rd_valid_in = 1'b0;
      rd_k_in     = rd_k_ff;
      rep_run_in  = rep_run_ff;
      reps_in     = reps_ff;
      pp_run_in   = pp_run_ff;
      cyc_in      = cyc_ff;

      if (cmd.accept) begin
         k_in       = IDX_W'(1);
         rep_run_in = 1'b1;
         reps_in    = CNT_W'(1);
         pp_run_in  = 1'b1;
         cyc_in     = '0;
         if (req_command == rapd_pkg::CMD_CLEAR) begin
            clear_in = 1'b1;
            fill_in  = '0;
         end else begin
            clear_in = 1'b0;
            sig_a_in = req_signature;
            fill_in  = (fill_sum > {1'b0, win_eff}) ? win_eff : fill_sum[CNT_W-1:0];
         end
      end

      if (cmd.issue) begin
         rd_valid_in = 1'b1;
         rd_k_in     = k_ff;
         k_in        = k_ff + IDX_W'(1);
      end

      if (rd_valid_ff) begin
         // trailing repeat run
         if (rep_run_ff && (rd_data == sig_a_ff)) begin
            reps_in = reps_ff + CNT_W'(1);
         end else begin
            rep_run_in = 1'b0;
         end
         // ping-pong pairs: entry one fixes B, even entries open a pair
         if (rd_k_ff == IDX_W'(1)) begin
            sig_b_in = rd_data;
            cyc_in   = CNT_W'(1);
         end else if (!rd_k_ff[0]) begin
            sig_x_in = rd_data;
         end else if (pp_run_ff && pair_ok) begin
            cyc_in = cyc_ff + CNT_W'(1);
         end else begin
            pp_run_in = 1'b0;
         end
      end
   end

   // Ping-pong needs four entries and two distinct newest values
   assign cyc_eff = ((fill_ff < CNT_W'(4)) || (sig_a_ff == sig_b_ff)) ? '0 : cyc_ff;

   // Classification into the result register
   always_comb begin
      sev_in       = sev_ff;
      kind_in      = kind_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (clear_ff) begin
            sev_in  = rapd_pkg::SEV_NONE;
            kind_in = rapd_pkg::KIND_NONE;
            run_in  = '0;
         end else if (32'(reps_ff) >= 32'(rcrit_ff)) begin
            sev_in  = rapd_pkg::SEV_CRIT;
            kind_in = rapd_pkg::KIND_REPEAT;
            run_in  = rapd_pkg::sat_run(reps_ff);
         end else if (32'(reps_ff) >= 32'(rwarn_ff)) begin
            sev_in  = rapd_pkg::SEV_WARN;
            kind_in = rapd_pkg::KIND_REPEAT;
            run_in  = rapd_pkg::sat_run(reps_ff);
         end else if (32'(cyc_eff) >= 32'(pcrit_ff)) begin
            sev_in  = rapd_pkg::SEV_CRIT;
            kind_in = rapd_pkg::KIND_PINGPONG;
            run_in  = rapd_pkg::sat_run(cyc_eff);
         end else if (32'(cyc_eff) >= 32'(pwarn_ff)) begin
            sev_in  = rapd_pkg::SEV_WARN;
            kind_in = rapd_pkg::KIND_PINGPONG;
            run_in  = rapd_pkg::sat_run(cyc_eff);
         end else begin
            sev_in  = rapd_pkg::SEV_NONE;
            kind_in = rapd_pkg::KIND_NONE;
            run_in  = '0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hp_ff        <= '0;
         fill_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ram_we) begin
            hp_ff <= hp_in;
         end
         fill_ff      <= fill_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      clear_ff   <= clear_in;
      sig_a_ff   <= sig_a_in;
      sig_b_ff   <= sig_b_in;
      sig_x_ff   <= sig_x_in;
      k_ff       <= k_in;
      rd_k_ff    <= rd_k_in;
      rep_run_ff <= rep_run_in;
      reps_ff    <= reps_in;
      pp_run_ff  <= pp_run_in;
      cyc_ff     <= cyc_in;
      sev_ff     <= sev_in;
      kind_ff    <= kind_in;
      run_ff     <= run_in;
   end

   // Status to the controller
   assign sts.last_read = (CNT_W'(k_ff) + CNT_W'(1)) == fill_ff;
   assign sts.no_reads  = fill_ff <= CNT_W'(1);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_severity  = sev_ff;
   assign rsp_loop_kind = kind_ff;
   assign rsp_run_count = run_ff;

endmodule

FILE: rtl/repeat_and_pingpong_detector_core.sv
// Flow: each transaction walks the older kept entries, newest first, before its
//   result is loaded; a clear or a single entry goes straight to the result.
//   A new transaction is taken only after that load, which waits for a free output.
// Reset: synchronous, active high; history empty, registers at their defaults,
//   no result pending. History RAM contents are not cleared.
module repeat_and_pingpong_detector_core (
   input  logic                              clock,
   input  logic                              reset,
   rapd_req_if.sink                          req_ch,
   rapd_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [rapd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rapd_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   rapd_pkg::dp_cmd_type cmd;
   rapd_pkg::dp_sts_type sts;
   logic                 req_ready;

   // Sequencer
   rapd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   // History, counters and result register
   rapd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_command   (req_ch.command),
      .req_signature (req_ch.signature),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_severity  (rsp_ch.severity),
      .rsp_loop_kind (rsp_ch.loop_kind),
      .rsp_run_count (rsp_ch.run_count)
   );

   // Result is only loaded when the output register is free
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result loaded over a pending transaction");

   // One transaction in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> !req_ch.ready)
      else $error("input taken while a transaction is in flight");

   // No detection means zero severity and zero count
   a_none_is_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.loop_kind == rapd_pkg::KIND_NONE)) |->
      ((rsp_ch.severity == rapd_pkg::SEV_NONE) && (rsp_ch.run_count == '0)))
      else $error("no-loop result with nonzero severity or count");

   // Reads are issued only while busy
   a_issue_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (!req_ch.ready && !cmd.finish))
      else $error("history read outside the walk");

endmodule
